// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ===== rtl/ffha_pkg.sv =====
// Package for the first-fit heap allocator: codes, record layout and defaults.
// No dependencies; used by ffha_table and first_fit_heap_allocator.
`default_nettype none
package ffha_pkg;

  localparam int unsigned MAX_BLOCKS_DEF   = 64;
  localparam int unsigned HEADER_BYTES_DEF = 16;

  localparam int unsigned ADDR_W  = 20;
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned LIMIT_W = 21;
  localparam logic [LIMIT_W-1:0] LIMIT_CAP = 21'd1048576;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_REALLOC = 2'd2,
    ACT_CALLOC  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_FULL      = 3'd3,
    ST_UNKNOWN   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_FIT,
    S_WR,
    S_OUT
  } state_t;

  // One block record as held in the table memory.
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
    logic              free;
  } entry_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] result_addr;
    logic [SIZE_W-1:0] granted_size;
    logic [ADDR_W-1:0] copy_from_addr;
    logic [SIZE_W-1:0] copy_bytes;
    logic              zero_fill;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/ffha_table.sv =====
// Block record memory: one write port, one read port with registered read data.
// Depends on ffha_pkg for the record type.
`default_nettype none
module ffha_table #(
  parameter int unsigned DEPTH = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire ffha_pkg::entry_t wdata,
  input  wire logic [AW-1:0]    raddr,
  output ffha_pkg::entry_t      rdata
);

  ffha_pkg::entry_t mem [DEPTH];
  ffha_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/first_fit_heap_allocator.sv =====
// Top level of the first-fit heap allocator: request sequencer and output register.
// Depends on ffha_pkg, ffha_table and assert_macros.svh.
//
//   Channel   Direction  Transfer condition        Contents
//   in_*      input      in_tvalid & in_tready     request (action in tuser)
//   out_*     output     out_tvalid & out_tready   one result per request
//   cfg_*     input      cfg_we                    heap limit register
//
// A request walks the block table one record per cycle through the table
// memory, whose read data is registered. A free or a realloc of a nonzero
// payload address first searches for the record with that address; an
// alloc, a calloc or a growing realloc then searches for the first fitting
// free record. Up to two writes update the table (the second releases the
// old block of a moving realloc), and the result then moves into the output
// register. The worst case is a growing realloc near the end of a nearly full
// or full table. Reset (rst_n low at a rising edge) empties the
// table by clearing the block count and the heap top; the records themselves
// are not cleared. A new request is taken as soon as the sequencer is idle,
// even while the previous result still waits in the output register; a
// stalled output only holds the sequencer at its final step.
`default_nettype none
`include "assert_macros.svh"
module first_fit_heap_allocator #(
  parameter int unsigned MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata, low bit up: size_bytes[15:0], elem_count[31:16],
  // payload_addr[51:32], zero fill [55:52]
  input  wire logic [55:0] in_tdata,
  // in_tuser: action[1:0]
  input  wire logic [1:0]  in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata, low bit up: status[2:0], result_addr[22:3],
  // granted_size[38:23], copy_from_addr[58:39], copy_bytes[74:59],
  // zero_fill[75], zero fill [79:76]
  output logic [79:0]      out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_we,
  input  wire logic [20:0] cfg_wdata
);

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned AW = ffha_pkg::ADDR_W;
  localparam int unsigned SW = ffha_pkg::SIZE_W;
  localparam int unsigned LW = ffha_pkg::LIMIT_W;

  // Control state.
  ffha_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [LW-1:0]    top_r, top_nxt;
  logic [LW-1:0]    limit_r;
  logic [CW-1:0]    scan_idx_r, scan_idx_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic             second_r, second_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload state.
  ffha_pkg::action_t act_r, act_nxt;
  logic [SW-1:0]     req_r, req_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [IW-1:0]     chk_idx_r, chk_idx_nxt;
  logic [IW-1:0]     old_idx_r, old_idx_nxt;
  logic [SW-1:0]     old_size_r, old_size_nxt;
  logic [IW-1:0]     wr_idx_r, wr_idx_nxt;
  ffha_pkg::entry_t  wr_ent_r, wr_ent_nxt;
  ffha_pkg::result_t res_r, res_nxt;
  ffha_pkg::result_t out_r, out_nxt;

  // Request fields on the input channel.
  ffha_pkg::action_t in_act;
  logic [SW-1:0]     in_size;
  logic [SW-1:0]     in_count;
  logic [AW-1:0]     in_addr;
  logic [SW-1:0]     in_req;
  logic              in_alloc_like;
  logic              accept;

  assign in_act   = ffha_pkg::action_t'(in_tuser);
  assign in_size  = in_tdata[15:0];
  assign in_count = in_tdata[31:16];
  assign in_addr  = in_tdata[51:32];
  // Calloc asks for the product wrapped to 16 bits; a zero factor gives zero.
  assign in_req   = (in_act == ffha_pkg::ACT_CALLOC) ? SW'(in_count * in_size) : in_size;
  assign in_alloc_like = (in_act == ffha_pkg::ACT_ALLOC) || (in_act == ffha_pkg::ACT_CALLOC) ||
                         ((in_act == ffha_pkg::ACT_REALLOC) && (in_addr == '0));
  assign accept = in_tvalid && in_tready;

  // Table memory and the scan that feeds it.
  ffha_pkg::entry_t rd_ent;
  logic             mem_we;
  logic             issue;
  logic             match;
  logic             hit;
  logic             miss;
  logic             move;
  logic [LW:0]      top_hdr;
  logic [LW:0]      top_end;

  assign issue  = ((state_r == ffha_pkg::S_FIND) || (state_r == ffha_pkg::S_FIT)) &&
                  (scan_idx_r < count_r);
  assign match  = (state_r == ffha_pkg::S_FIND) ? (rd_ent.base == addr_r)
                                                : (rd_ent.free && (rd_ent.size >= req_r));
  assign hit    = chk_vld_r && match;
  assign miss   = !chk_vld_r && !issue;
  assign mem_we = (state_r == ffha_pkg::S_WR);
  // A realloc that leaves its old block behind.
  assign move   = (act_r == ffha_pkg::ACT_REALLOC) && (addr_r != '0);

  assign top_hdr = {1'b0, top_r} + (LW + 1)'(HEADER_BYTES);
  assign top_end = top_hdr + (LW + 1)'(req_r);

  ffha_table #(
    .DEPTH (MAX_BLOCKS),
    .AW    (IW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_idx_r),
    .wdata (wr_ent_r),
    .raddr (scan_idx_r[IW-1:0]),
    .rdata (rd_ent)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    top_nxt       = top_r;
    scan_idx_nxt  = scan_idx_r;
    chk_vld_nxt   = chk_vld_r;
    chk_idx_nxt   = chk_idx_r;
    second_nxt    = second_r;
    act_nxt       = act_r;
    req_nxt       = req_r;
    addr_nxt      = addr_r;
    old_idx_nxt   = old_idx_r;
    old_size_nxt  = old_size_r;
    wr_idx_nxt    = wr_idx_r;
    wr_ent_nxt    = wr_ent_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = (state_r == ffha_pkg::S_IDLE);

    // Scan bookkeeping; overridden where a search starts or ends.
    if (issue) begin
      scan_idx_nxt = scan_idx_r + CW'(1);
    end
    chk_vld_nxt = issue;
    chk_idx_nxt = scan_idx_r[IW-1:0];

    unique case (state_r)
      ffha_pkg::S_IDLE: begin
        chk_vld_nxt  = 1'b0;
        scan_idx_nxt = '0;
        if (accept) begin
          act_nxt    = in_act;
          req_nxt    = in_req;
          addr_nxt   = in_addr;
          second_nxt = 1'b0;
          res_nxt    = '0;
          if (in_alloc_like) begin
            if (in_req == '0) begin
              res_nxt.status = ffha_pkg::ST_ZERO;
              state_nxt      = ffha_pkg::S_OUT;
            end else begin
              state_nxt = ffha_pkg::S_FIT;
            end
          end else if ((in_act == ffha_pkg::ACT_FREE) && (in_addr == '0)) begin
            state_nxt = ffha_pkg::S_OUT;
          end else begin
            state_nxt = ffha_pkg::S_FIND;
          end
        end
      end

      ffha_pkg::S_FIND: begin
        if (hit) begin
          if (act_r == ffha_pkg::ACT_FREE) begin
            wr_idx_nxt      = chk_idx_r;
            wr_ent_nxt      = rd_ent;
            wr_ent_nxt.free = 1'b1;
            state_nxt       = ffha_pkg::S_WR;
          end else begin
            old_idx_nxt  = chk_idx_r;
            old_size_nxt = rd_ent.size;
            if (req_r <= rd_ent.size) begin
              res_nxt.result_addr  = addr_r;
              res_nxt.granted_size = rd_ent.size;
              state_nxt            = ffha_pkg::S_OUT;
            end else begin
              scan_idx_nxt = '0;
              chk_vld_nxt  = 1'b0;
              state_nxt    = ffha_pkg::S_FIT;
            end
          end
        end else if (miss) begin
          res_nxt.status = ffha_pkg::ST_UNKNOWN;
          state_nxt      = ffha_pkg::S_OUT;
        end
      end

      ffha_pkg::S_FIT: begin
        if (hit || (miss && (count_r != CW'(MAX_BLOCKS)) &&
                    (top_end <= {1'b0, limit_r}))) begin
          if (hit) begin
            // Reuse the first fitting free block whole.
            wr_idx_nxt = chk_idx_r;
            wr_ent_nxt = rd_ent;
          end else begin
            // Append a new block at the heap top.
            wr_idx_nxt      = count_r[IW-1:0];
            wr_ent_nxt.base = top_hdr[AW-1:0];
            wr_ent_nxt.size = req_r;
            count_nxt       = count_r + CW'(1);
            top_nxt         = top_end[LW-1:0];
          end
          wr_ent_nxt.free      = 1'b0;
          res_nxt.result_addr  = hit ? rd_ent.base : top_hdr[AW-1:0];
          res_nxt.granted_size = hit ? rd_ent.size : req_r;
          res_nxt.zero_fill    = (act_r == ffha_pkg::ACT_CALLOC);
          if (move) begin
            res_nxt.copy_from_addr = addr_r;
            res_nxt.copy_bytes     = old_size_r;
            second_nxt             = 1'b1;
          end
          state_nxt = ffha_pkg::S_WR;
        end else if (miss) begin
          res_nxt.status = (count_r == CW'(MAX_BLOCKS)) ? ffha_pkg::ST_FULL
                                                        : ffha_pkg::ST_EXHAUSTED;
          state_nxt      = ffha_pkg::S_OUT;
        end
      end

      ffha_pkg::S_WR: begin
        if (second_r) begin
          // Release the old block of a moving realloc.
          second_nxt      = 1'b0;
          wr_idx_nxt      = old_idx_r;
          wr_ent_nxt.base = addr_r;
          wr_ent_nxt.size = old_size_r;
          wr_ent_nxt.free = 1'b1;
        end else begin
          state_nxt = ffha_pkg::S_OUT;
        end
      end

      ffha_pkg::S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ffha_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ffha_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffha_pkg::S_IDLE;
      count_r     <= '0;
      top_r       <= '0;
      limit_r     <= ffha_pkg::LIMIT_CAP;
      scan_idx_r  <= '0;
      chk_vld_r   <= 1'b0;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      top_r       <= top_nxt;
      scan_idx_r  <= scan_idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
      // Limits above the addressable heap act as the full heap.
      if (cfg_we) begin
        limit_r <= (cfg_wdata > ffha_pkg::LIMIT_CAP) ? ffha_pkg::LIMIT_CAP : cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    req_r      <= req_nxt;
    addr_r     <= addr_nxt;
    chk_idx_r  <= chk_idx_nxt;
    old_idx_r  <= old_idx_nxt;
    old_size_r <= old_size_nxt;
    wr_idx_r   <= wr_idx_nxt;
    wr_ent_r   <= wr_ent_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_r.zero_fill, out_r.copy_bytes, out_r.copy_from_addr,
                       out_r.granted_size, out_r.result_addr, out_r.status};

  `ASSERT_NEVER(a_count_range, count_r > CW'(MAX_BLOCKS), "block count above table depth")
  `ASSERT_NEVER(a_top_range, top_r > ffha_pkg::LIMIT_CAP, "heap top beyond addressable heap")
  `ASSERT_CLK(a_wr_in_table, mem_we |-> (CW'(wr_idx_r) < count_r), "write outside live table")
  `ASSERT_CLK(a_one_at_a_time, accept |=> !in_tready, "request taken while one is in progress")

endmodule
`default_nettype wire
